FILE: sv/svpwm_pkg.sv
// ============================================================================
// svpwm_pkg
// Shared constants, calibration tables and types for the servo angle to
// PWM register write block.
// ============================================================================
package svpwm_pkg;

    // Controller register map
    localparam int CHANNEL_COUNT    = 16;
    localparam int BASE_REGISTER    = 6;
    localparam int BREAKPOINT_COUNT = 9;
    localparam int SEG_COUNT        = BREAKPOINT_COUNT - 1;
    localparam int SEG_W            = $clog2(SEG_COUNT);
    localparam int BP_IDX_W         = $clog2(BREAKPOINT_COUNT);

    // Field widths
    localparam int CHAN_W  = 4;
    localparam int ANGLE_W = 13;
    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 8;
    localparam int PWM_W   = 12;
    localparam int ON_W    = 9;   // on count never exceeds 260

    localparam logic [PWM_W-1:0] PWM_FULL = 12'hFFF;
    localparam int               ON_MAX   = 260;

    // Breakpoint angles in whole degrees
    localparam int BP_DEG [BREAKPOINT_COUNT] = '{0, 30, 45, 60, 90, 120, 135, 150, 180};

    // Duty tables in units of 1/20000, one row per servo type
    localparam int DUTY_TAB [2][BREAKPOINT_COUNT] = '{
        '{290, 370, 450, 560, 700, 800, 880, 1020, 1100},
        '{300, 420, 500, 650, 800, 950, 1050, 1180, 1270}
    };

    // All segments are scaled to a common width of SEG_LCM degrees
    localparam int SEG_LCM = 30;
    localparam int SEG_MULT [SEG_COUNT] = '{1, 2, 2, 1, 1, 2, 2, 1};

    // Duty result handed from the interpolator to the write sequencer
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [ON_W-1:0]   on;
    } svpwm_duty_t;

endpackage

FILE: sv/svpwm_interp.sv
// ============================================================================
// svpwm_interp
// Four stage interpolation pipeline: clamp and segment pick, slope multiply,
// scale by 273/1024, and divide by 625 through a reciprocal.
// ============================================================================
module svpwm_interp
    import svpwm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      servo_model,
    input  logic [CHAN_W-1:0]         channel,
    input  logic signed [ANGLE_W-1:0] angle_sixteenths,
    output logic                      duty_valid,
    input  logic                      duty_ready,
    output svpwm_duty_t               duty
);

    localparam int S_MAX   = BP_DEG[BREAKPOINT_COUNT-1] * 16;
    localparam int SPAN_W  = 12;
    localparam int DS_W    = 9;
    localparam int DY_W    = 8;
    localparam int NUM_W   = 20;
    localparam int P_W     = 28;
    localparam int Q_W     = 18;
    // 4095/(20000*16*30) reduces to 273/640000 = 273 / (1024 * 625)
    localparam int K_SCALE = 273;
    localparam int Q_SHIFT = 10;
    // Reciprocal of 625 with 28 fraction bits, exact for Q below 2^18
    localparam int R_SHIFT = 28;
    localparam logic [18:0] R_MULT = 19'd429497;

    // Stage valid bits and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !v4_reg || duty_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // Stage payloads
    logic [CHAN_W-1:0] ch1_reg, ch2_reg, ch3_reg, ch4_reg;
    logic [NUM_W-1:0]  base1_reg;
    logic [DS_W-1:0]   ds1_reg;
    logic [DY_W-1:0]   dy1_reg;
    logic [NUM_W-1:0]  num2_reg;
    logic [Q_W-1:0]    q3_reg;
    logic [ON_W-1:0]   on4_reg;

    logic [NUM_W-1:0]  base1_next;
    logic [DS_W-1:0]   ds1_next;
    logic [DY_W-1:0]   dy1_next;
    logic [NUM_W-1:0]  num2_next;
    logic [Q_W-1:0]    q3_next;
    logic [ON_W-1:0]   on4_next;

    // Stage 1: clamp the angle, pick the segment, fetch its constants
    logic [SPAN_W-1:0]   s_clamp;
    logic [SEG_W-1:0]    seg;
    logic [BP_IDX_W-1:0] idx_lo;
    logic [BP_IDX_W-1:0] idx_hi;
    logic [SPAN_W-1:0]   d_full;

    always_comb
    begin
        if (angle_sixteenths <= 0)
            s_clamp = '0;
        else if (int'(angle_sixteenths) >= S_MAX)
            s_clamp = SPAN_W'(S_MAX);
        else
            s_clamp = SPAN_W'(angle_sixteenths);

        seg = SEG_W'(SEG_COUNT - 1);
        for (int j = SEG_COUNT - 1; j >= 0; j--)
        begin
            if (int'(s_clamp) <= BP_DEG[j+1] * 16)
                seg = SEG_W'(j);
        end

        idx_lo     = BP_IDX_W'(seg);
        idx_hi     = idx_lo + BP_IDX_W'(1);
        d_full     = s_clamp - SPAN_W'(BP_DEG[idx_lo] * 16);
        ds1_next   = DS_W'(d_full * SPAN_W'(SEG_MULT[seg]));
        base1_next = NUM_W'(DUTY_TAB[servo_model][idx_lo] * 16 * SEG_LCM);
        dy1_next   = DY_W'(DUTY_TAB[servo_model][idx_hi] - DUTY_TAB[servo_model][idx_lo]);
    end

    // Stage 2: add the slope term
    assign num2_next = base1_reg + NUM_W'(ds1_reg * dy1_reg);

    // Stage 3: scale by 273 and drop the power-of-two part of the divisor
    logic [P_W-1:0] p3;
    assign p3      = P_W'(num2_reg * P_W'(K_SCALE));
    assign q3_next = p3[P_W-1:Q_SHIFT];

    // Stage 4: divide by 625 through the reciprocal
    logic [Q_W+19-1:0] r4;
    assign r4       = (Q_W+19)'(q3_reg) * (Q_W+19)'(R_MULT);
    assign on4_next = r4[R_SHIFT +: ON_W];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // Advance payloads
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            ch1_reg   <= channel;
            base1_reg <= base1_next;
            ds1_reg   <= ds1_next;
            dy1_reg   <= dy1_next;
        end
        if (adv2)
        begin
            ch2_reg  <= ch1_reg;
            num2_reg <= num2_next;
        end
        if (adv3)
        begin
            ch3_reg <= ch2_reg;
            q3_reg  <= q3_next;
        end
        if (adv4)
        begin
            ch4_reg <= ch3_reg;
            on4_reg <= on4_next;
        end
    end

    assign duty_valid   = v4_reg;
    assign duty.channel = ch4_reg;
    assign duty.on      = on4_reg;

endmodule

FILE: sv/servo_angle_to_pwm_writes.sv
// ============================================================================
// servo_angle_to_pwm_writes
// Maps a servo angle to PWM on/off counts and emits four register writes.
// ============================================================================
// Flow: an item passes the four pipeline stages and then the write register,
// which offers its four writes back to back while the output does not stall.
// The single write output port (four writes per item) bounds the item rate;
// the four-stage pipeline accepts an item per cycle unless back-pressure
// holds it.
// Reset: rst_n clears all valid bits and the write counter; no clearing pass.
module servo_angle_to_pwm_writes
    import svpwm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      servo_model,
    input  logic [CHAN_W-1:0]         channel,
    input  logic signed [ANGLE_W-1:0] angle_sixteenths,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ADDR_W-1:0]         reg_address,
    output logic [DATA_W-1:0]         reg_data,
    output logic                      last
);

    typedef enum logic [1:0] {
        BEAT_OFF_LO = 2'd0,
        BEAT_OFF_HI = 2'd1,
        BEAT_ON_LO  = 2'd2,
        BEAT_ON_HI  = 2'd3
    } beat_t;

    logic        duty_valid;
    logic        duty_ready;
    svpwm_duty_t duty;

    svpwm_interp u_interp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .servo_model      (servo_model),
        .channel          (channel),
        .angle_sixteenths (angle_sixteenths),
        .duty_valid       (duty_valid),
        .duty_ready       (duty_ready),
        .duty             (duty)
    );

    // Write sequencer state
    logic              out_valid_reg;
    beat_t             beat_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic [PWM_W-1:0]  on_reg;
    logic [PWM_W-1:0]  off_reg;
    logic [PWM_W-1:0]  on_next;

    logic beat_done;
    assign beat_done  = out_valid_reg && out_ready;
    assign duty_ready = !out_valid_reg || (beat_done && beat_reg == BEAT_ON_HI);
    assign on_next    = PWM_W'(duty.on);

    // Load a new item or step through its four writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            beat_reg      <= BEAT_OFF_LO;
        end
        else if (duty_ready)
        begin
            out_valid_reg <= duty_valid;
            beat_reg      <= BEAT_OFF_LO;
        end
        else if (beat_done)
        begin
            beat_reg <= beat_t'(beat_reg + 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (duty_ready && duty_valid)
        begin
            chan_reg <= duty.channel;
            on_reg   <= on_next;
            off_reg  <= PWM_FULL - on_next;
        end
    end

    // Present the current write
    always_comb
    begin
        unique case (beat_reg)
            BEAT_OFF_LO: reg_data = off_reg[7:0];
            BEAT_OFF_HI: reg_data = DATA_W'(off_reg[PWM_W-1:8]);
            BEAT_ON_LO:  reg_data = on_reg[7:0];
            BEAT_ON_HI:  reg_data = DATA_W'(on_reg[PWM_W-1:8]);
            default:     reg_data = '0;
        endcase
    end

    assign reg_address = ADDR_W'(BASE_REGISTER) + ADDR_W'({chan_reg, 2'b00})
                       + ADDR_W'(beat_reg);
    assign out_valid   = out_valid_reg;
    assign last        = (beat_reg == BEAT_ON_HI);

    // Writes of one item go to consecutive addresses without a gap
    a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=>
            (out_valid && reg_address == $past(reg_address) + 8'd1))
        else $error("write sequence broke between beats");

    // On and off counts always add to the full period
    a_on_off_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((13'(on_reg) + 13'(off_reg)) == 13'(PWM_FULL)))
        else $error("on and off counts do not sum to full period");

    // On count stays within the calibrated range
    a_on_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (on_reg <= PWM_W'(ON_MAX)))
        else $error("on count beyond calibrated maximum");

    // A finished item is taken from the pipeline only when its last write leaves
    a_no_early_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !(out_ready && last)) |-> !duty_ready)
        else $error("sequencer reloaded before last write");

endmodule

FILE: sim/servo_angle_to_pwm_writes_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_angle_to_pwm_writes_tb
// Drives servo angle items into the block and checks every register write.
// A behavioral model interpolates the duty tables and queues the four
// expected writes of each accepted item. Random idling on both channels,
// one long output stall and drain pauses exercise the handshakes.
// ----------------------------------------------------------------------------
module servo_angle_to_pwm_writes_tb;
    import svpwm_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int STALL_CYCLES  = 200;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS  = 125;
    localparam int MAX_REPORTS   = 10;
    localparam int DUTY_SCALE    = 20000;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
    } pwm_write_t;

    logic                      clk              = 1'b0;
    logic                      rst_n            = 1'b0;
    logic                      in_valid         = 1'b0;
    logic                      in_ready;
    logic                      servo_model      = 1'b0;
    logic [CHAN_W-1:0]         channel          = '0;
    logic signed [ANGLE_W-1:0] angle_sixteenths = '0;
    logic                      out_valid;
    logic                      out_ready        = 1'b0;
    logic [ADDR_W-1:0]         reg_address;
    logic [DATA_W-1:0]         reg_data;
    logic                      last;

    pwm_write_t expected_writes[$];
    int         mismatch_count = 0;
    int         idle_cycles    = 0;
    bit         no_idle        = 1'b0;
    bit         stall_request  = 1'b0;

    servo_angle_to_pwm_writes dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .servo_model      (servo_model),
        .channel          (channel),
        .angle_sixteenths (angle_sixteenths),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .reg_address      (reg_address),
        .reg_data         (reg_data),
        .last             (last)
    );

    always #10 clk = ~clk;

    // Interpolate the duty table and scale to the PWM on count
    function automatic int pwm_on_count(input logic model, input logic signed [ANGLE_W-1:0] ang);
        longint s;
        longint dx;
        longint dy;
        longint num;
        s = ang;
        if (s <= BP_DEG[0] * 16)
            return (4095 * DUTY_TAB[model][0]) / DUTY_SCALE;
        if (s >= BP_DEG[BREAKPOINT_COUNT-1] * 16)
            return (4095 * DUTY_TAB[model][BREAKPOINT_COUNT-1]) / DUTY_SCALE;
        for (int i = 1; i < BREAKPOINT_COUNT; i++)
        begin
            if (s <= BP_DEG[i] * 16)
            begin
                dx = BP_DEG[i] - BP_DEG[i-1];
                dy = DUTY_TAB[model][i] - DUTY_TAB[model][i-1];
                if (dx <= 0)
                    return (4095 * DUTY_TAB[model][i]) / DUTY_SCALE;
                num = DUTY_TAB[model][i-1] * 16 * dx + (s - 16 * BP_DEG[i-1]) * dy;
                if (num < 0)
                    num = 0;
                return int'((num * 4095) / (longint'(DUTY_SCALE) * 16 * dx));
            end
        end
        return (4095 * DUTY_TAB[model][BREAKPOINT_COUNT-1]) / DUTY_SCALE;
    endfunction

    // Queue the four writes one accepted item produces
    task automatic queue_pwm_writes(input logic model, input logic [CHAN_W-1:0] ch,
                                    input logic signed [ANGLE_W-1:0] ang);
        logic [PWM_W-1:0] on_cnt;
        logic [PWM_W-1:0] off_cnt;
        logic [DATA_W-1:0] bytes [4];
        pwm_write_t wr;
        on_cnt  = PWM_W'(pwm_on_count(model, ang));
        off_cnt = PWM_FULL - on_cnt;
        bytes[0] = off_cnt[7:0];
        bytes[1] = DATA_W'(off_cnt >> 8);
        bytes[2] = on_cnt[7:0];
        bytes[3] = DATA_W'(on_cnt >> 8);
        for (int k = 0; k < 4; k++)
        begin
            wr.addr = ADDR_W'(BASE_REGISTER + 4 * ch + k);
            wr.data = bytes[k];
            wr.last = (k == 3);
            expected_writes.push_back(wr);
        end
    endtask

    // Offer one item after a random gap and hold it until accepted
    task automatic send_angle(input logic model, input logic [CHAN_W-1:0] ch,
                              input logic signed [ANGLE_W-1:0] ang);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        servo_model      <= model;
        channel          <= ch;
        angle_sixteenths <= ang;
        do
            @(posedge clk);
        while (!in_ready);
        queue_pwm_writes(model, ch, ang);
    endtask

    // Stop offering and wait until every expected write has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Clamp ends, every breakpoint of both tables, and full-scale field values
    task automatic test_directed();
        for (int i = 0; i < BREAKPOINT_COUNT; i++)
            send_angle(1'b0, CHAN_W'(i), ANGLE_W'(BP_DEG[i] * 16));
        for (int i = 0; i < BREAKPOINT_COUNT; i++)
            send_angle(1'b1, CHAN_W'(15 - i), ANGLE_W'(BP_DEG[i] * 16));
        send_angle(1'b0, 4'd15, -13'sd4096);
        send_angle(1'b1, 4'd0, -13'sd1);
        send_angle(1'b1, 4'd15, 13'sd4095);
        send_angle(1'b0, 4'd5, 13'sd2881);
        send_angle(1'b1, 4'd10, 13'sd1);
        send_angle(1'b0, 4'd3, 13'sd2879);
    endtask

    // Mostly in-range angles, some near the clamps, some anywhere
    task automatic test_random();
        int pick;
        logic signed [ANGLE_W-1:0] ang;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= 50 && n < 70);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                ang = ANGLE_W'($urandom_range(0, 2880));
            else if (pick < 78)
                ang = ANGLE_W'(int'($urandom_range(0, 64)) - 32);
            else if (pick < 86)
                ang = ANGLE_W'(2880 + int'($urandom_range(0, 64)) - 32);
            else
                ang = ANGLE_W'($urandom);
            send_angle(1'($urandom), CHAN_W'($urandom), ang);
        end
        no_idle = 1'b0;
    endtask

    // Stall the output for a long stretch while items keep coming
    task automatic test_backpressure();
        stall_request = 1'b1;
        no_idle       = 1'b1;
        for (int n = 0; n < 24; n++)
            send_angle(1'($urandom), CHAN_W'($urandom), ANGLE_W'($urandom_range(0, 2880)));
        no_idle = 1'b0;
    endtask

    // Output ready: random stalls, or a long hold when one is requested
    initial
    begin
        int stall;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (stall_request)
            begin
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_request = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Compare each accepted write against the oldest expectation
    always @(posedge clk)
    begin
        pwm_write_t exp_wr;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_writes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected write: addr=%0d data=%0d last=%0b",
                             reg_address, reg_data, last);
            end
            else
            begin
                exp_wr = expected_writes.pop_front();
                if (reg_address !== exp_wr.addr || reg_data !== exp_wr.data
                    || last !== exp_wr.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $write("write mismatch: expected addr=%0d data=%0d last=%0b,",
                               exp_wr.addr, exp_wr.data, exp_wr.last);
                        $display(" got addr=%0d data=%0d last=%0b",
                                 reg_address, reg_data, last);
                    end
                end
            end
        end
    end

    // End the run when no item moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_random();
        wait_drained();
        test_backpressure();
        wait_drained();
        test_random();
        wait_drained();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
